[src/ptfa_pkg.sv]
// ----------------------------------------------------------------------------
// ptfa_pkg
// Shared types and constants of the page table frame allocator.
// ----------------------------------------------------------------------------
package ptfa_pkg;

    localparam int PTFA_PAGES  = 64;
    localparam int PTFA_FRAMES = 256;

    // Bitmap is stored as rows of this many frame bits
    localparam int MAP_WORD_W = 32;
    localparam int MAP_BIT_W  = 5;

    // Request kinds
    localparam logic KIND_GROW   = 1'b0;
    localparam logic KIND_SHRINK = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_FRAMES = 2'd1,
        STATUS_TOO_BIG   = 2'd2
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [5:0] page_index;
        logic [7:0] frame_number;
        logic       changed;
        logic [6:0] valid_pages;
        logic       last;
    } rsp_t;

endpackage

[src/ptfa_bitmap.sv]
// ----------------------------------------------------------------------------
// ptfa_bitmap
// Frame occupancy bitmap: one synchronous RAM of 32-bit rows, one write and
// one read port and a registered read. A per-row valid bit makes rows that
// were never written read as all free.
// ----------------------------------------------------------------------------
module ptfa_bitmap
    import ptfa_pkg::*;
#(
    parameter int FRAMES = PTFA_FRAMES
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         rd_en,
    input  logic [((FRAMES + MAP_WORD_W - 1) / MAP_WORD_W > 1 ?
                  $clog2((FRAMES + MAP_WORD_W - 1) / MAP_WORD_W) : 1) - 1:0] rd_addr,
    output logic [MAP_WORD_W-1:0]                        rd_data,
    input  logic                                         wr_en,
    input  logic [((FRAMES + MAP_WORD_W - 1) / MAP_WORD_W > 1 ?
                  $clog2((FRAMES + MAP_WORD_W - 1) / MAP_WORD_W) : 1) - 1:0] wr_addr,
    input  logic [MAP_WORD_W-1:0]                        wr_data
);

    localparam int MAP_WORDS = (FRAMES + MAP_WORD_W - 1) / MAP_WORD_W;

    logic [MAP_WORD_W-1:0] map_mem [MAP_WORDS];
    logic                  row_valid_reg [MAP_WORDS];
    logic [MAP_WORD_W-1:0] rdata_reg;
    logic                  rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_WORDS; i++)
            begin
                row_valid_reg[i] <= 1'b0;
            end
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // Unwritten rows hold no frames in use
    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

[src/ptfa_table.sv]
// ----------------------------------------------------------------------------
// ptfa_table
// Page table RAM: frame number of each valid page, one write and one read
// port and a registered read. Only valid pages are ever read back.
// ----------------------------------------------------------------------------
module ptfa_table
    import ptfa_pkg::*;
#(
    parameter int PAGES  = PTFA_PAGES,
    parameter int FRAMES = PTFA_FRAMES
)
(
    input  logic                                    clk,
    input  logic                                    rd_en,
    input  logic [(PAGES > 1 ? $clog2(PAGES) : 1)-1:0] rd_addr,
    output logic [$clog2(FRAMES)-1:0]               rd_data,
    input  logic                                    wr_en,
    input  logic [(PAGES > 1 ? $clog2(PAGES) : 1)-1:0] wr_addr,
    input  logic [$clog2(FRAMES)-1:0]               wr_data
);

    logic [$clog2(FRAMES)-1:0] page_mem [PAGES];
    logic [$clog2(FRAMES)-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            page_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= page_mem[rd_addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

[src/ptfa_ctrl.sv]
// ----------------------------------------------------------------------------
// ptfa_ctrl
// Request sequencer: checks a request against the counters, walks the bitmap
// for free frames on grow, releases frames from the top page on shrink, and
// holds each result in an output register.
// ----------------------------------------------------------------------------
module ptfa_ctrl
    import ptfa_pkg::*;
#(
    parameter int PAGES  = PTFA_PAGES,
    parameter int FRAMES = PTFA_FRAMES
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    // request
    input  logic                                         req_valid,
    output logic                                         req_ready,
    input  logic                                         req_kind,
    input  logic [6:0]                                   req_count,
    // result
    output logic                                         rsp_valid,
    input  logic                                         rsp_ready,
    output rsp_t                                         rsp,
    // bitmap RAM
    output logic                                         map_rd_en,
    output logic [((FRAMES + MAP_WORD_W - 1) / MAP_WORD_W > 1 ?
                  $clog2((FRAMES + MAP_WORD_W - 1) / MAP_WORD_W) : 1) - 1:0] map_rd_addr,
    input  logic [MAP_WORD_W-1:0]                        map_rd_data,
    output logic                                         map_wr_en,
    output logic [((FRAMES + MAP_WORD_W - 1) / MAP_WORD_W > 1 ?
                  $clog2((FRAMES + MAP_WORD_W - 1) / MAP_WORD_W) : 1) - 1:0] map_wr_addr,
    output logic [MAP_WORD_W-1:0]                        map_wr_data,
    // page table RAM
    output logic                                         tbl_rd_en,
    output logic [(PAGES > 1 ? $clog2(PAGES) : 1)-1:0]   tbl_rd_addr,
    input  logic [$clog2(FRAMES)-1:0]                    tbl_rd_data,
    output logic                                         tbl_wr_en,
    output logic [(PAGES > 1 ? $clog2(PAGES) : 1)-1:0]   tbl_wr_addr,
    output logic [$clog2(FRAMES)-1:0]                    tbl_wr_data
);

    localparam int MAP_WORDS = (FRAMES + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int WIW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PIW       = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int FW        = $clog2(FRAMES);
    localparam int FCW       = $clog2(FRAMES + 1);
    localparam int CMPW      = (FCW > 7) ? FCW : 7;
    localparam int FULLW     = WIW + MAP_BIT_W;
    localparam int F8W       = FW + 8;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_G_READ = 6'b000010,
        ST_G_LOAD = 6'b000100,
        ST_G_PICK = 6'b001000,
        ST_S_RDP  = 6'b010000,
        ST_S_RDB  = 6'b100000
    } state_t;

    // Shrink clear step is taken in ST_S_RDB's successor
    typedef enum logic {
        CLR_OFF = 1'b0,
        CLR_ON  = 1'b1
    } clr_t;

    state_t                state_reg, state_next;
    clr_t                  clr_reg, clr_next;
    logic [6:0]            valid_cnt_reg, valid_cnt_next;
    logic [FCW-1:0]        free_cnt_reg, free_cnt_next;
    logic [6:0]            target_reg, target_next;
    logic [6:0]            rem_reg, rem_next;
    logic [WIW-1:0]        widx_reg, widx_next;
    logic [MAP_WORD_W-1:0] word_reg, word_next;
    logic [FW-1:0]         frame_reg, frame_next;
    logic                  out_valid_reg, out_valid_next;
    rsp_t                  out_reg, out_next;

    logic                  out_free;
    logic                  emit;
    rsp_t                  res;
    logic [MAP_BIT_W-1:0]  pick;
    logic [MAP_WORD_W-1:0] word_new;
    logic [FULLW-1:0]      pick_frame;
    logic [FULLW-1:0]      rd_frame_x;
    logic [FULLW-1:0]      cur_frame_x;
    logic [F8W-1:0]        pick_frame8;
    logic [F8W-1:0]        cur_frame8;
    logic [6:0]            need;
    logic [6:0]            rel;
    logic [6:0]            valid_inc;
    logic [6:0]            valid_dec;

    // Lowest free frame bit of the current row
    always_comb
    begin
        pick = '0;
        for (int i = MAP_WORD_W - 1; i >= 0; i--)
        begin
            if (!word_reg[i])
            begin
                pick = MAP_BIT_W'(i);
            end
        end
    end

    assign word_new    = word_reg | (MAP_WORD_W'(1) << pick);
    assign pick_frame  = {widx_reg, pick};
    assign pick_frame8 = F8W'(pick_frame[FW-1:0]);
    assign rd_frame_x  = FULLW'(tbl_rd_data);
    assign cur_frame_x = FULLW'(frame_reg);
    assign cur_frame8  = F8W'(frame_reg);
    assign need        = req_count - valid_cnt_reg;
    assign rel         = (req_count > valid_cnt_reg) ? valid_cnt_reg : req_count;
    assign valid_inc   = valid_cnt_reg + 7'd1;
    assign valid_dec   = valid_cnt_reg - 7'd1;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && (clr_reg == CLR_OFF) && out_free;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        valid_cnt_next = valid_cnt_reg;
        free_cnt_next  = free_cnt_reg;
        target_next    = target_reg;
        rem_next       = rem_reg;
        widx_next      = widx_reg;
        word_next      = word_reg;
        frame_next     = frame_reg;
        emit           = 1'b0;
        res            = '0;
        res.valid_pages = valid_cnt_reg;
        res.last       = 1'b1;
        map_rd_en      = 1'b0;
        map_rd_addr    = widx_reg;
        map_wr_en      = 1'b0;
        map_wr_addr    = widx_reg;
        map_wr_data    = word_new;
        tbl_rd_en      = 1'b0;
        tbl_rd_addr    = valid_dec[PIW-1:0];
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = valid_cnt_reg[PIW-1:0];
        tbl_wr_data    = pick_frame[FW-1:0];

        if (clr_reg == CLR_ON)
        begin
            // Release the top page: frame row is in map_rd_data
            map_wr_addr = cur_frame_x[FULLW-1:MAP_BIT_W];
            map_wr_data = map_rd_data
                          & ~(MAP_WORD_W'(1) << cur_frame_x[MAP_BIT_W-1:0]);
            if (out_free)
            begin
                map_wr_en        = 1'b1;
                free_cnt_next    = free_cnt_reg + FCW'(1);
                valid_cnt_next   = valid_dec;
                rem_next         = rem_reg - 7'd1;
                emit             = 1'b1;
                res.status       = STATUS_OK;
                res.page_index   = valid_dec[5:0];
                res.frame_number = cur_frame8[7:0];
                res.changed      = 1'b1;
                res.valid_pages  = valid_dec;
                res.last         = (rem_reg == 7'd1);
                clr_next         = CLR_OFF;
                state_next       = (rem_reg == 7'd1) ? ST_IDLE : ST_S_RDP;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid && req_ready)
                    begin
                        if (req_kind == KIND_GROW)
                        begin
                            if (req_count > 7'(PAGES))
                            begin
                                emit       = 1'b1;
                                res.status = STATUS_TOO_BIG;
                            end
                            else if (req_count <= valid_cnt_reg)
                            begin
                                emit       = 1'b1;
                                res.status = STATUS_OK;
                            end
                            else if (CMPW'(need) > CMPW'(free_cnt_reg))
                            begin
                                emit       = 1'b1;
                                res.status = STATUS_NO_FRAMES;
                            end
                            else
                            begin
                                target_next = req_count;
                                widx_next   = '0;
                                state_next  = ST_G_READ;
                            end
                        end
                        else
                        begin
                            if (rel == 7'd0)
                            begin
                                emit       = 1'b1;
                                res.status = STATUS_OK;
                            end
                            else
                            begin
                                rem_next   = rel;
                                state_next = ST_S_RDP;
                            end
                        end
                    end
                end

                ST_G_READ:
                begin
                    map_rd_en  = 1'b1;
                    state_next = ST_G_LOAD;
                end

                ST_G_LOAD:
                begin
                    word_next  = map_rd_data;
                    state_next = ST_G_PICK;
                end

                ST_G_PICK:
                begin
                    if (&word_reg)
                    begin
                        // Row full: advance to the next one
                        widx_next  = widx_reg + WIW'(1);
                        state_next = ST_G_READ;
                    end
                    else if (out_free)
                    begin
                        map_wr_en        = 1'b1;
                        tbl_wr_en        = 1'b1;
                        word_next        = word_new;
                        free_cnt_next    = free_cnt_reg - FCW'(1);
                        valid_cnt_next   = valid_inc;
                        emit             = 1'b1;
                        res.status       = STATUS_OK;
                        res.page_index   = valid_cnt_reg[5:0];
                        res.frame_number = pick_frame8[7:0];
                        res.changed      = 1'b1;
                        res.valid_pages  = valid_inc;
                        res.last         = (valid_inc == target_reg);
                        if (valid_inc == target_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end

                ST_S_RDP:
                begin
                    tbl_rd_en  = 1'b1;
                    state_next = ST_S_RDB;
                end

                ST_S_RDB:
                begin
                    frame_next  = tbl_rd_data;
                    map_rd_en   = 1'b1;
                    map_rd_addr = rd_frame_x[FULLW-1:MAP_BIT_W];
                    clr_next    = CLR_ON;
                end

                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clr_reg       <= CLR_OFF;
            valid_cnt_reg <= '0;
            free_cnt_reg  <= FCW'(FRAMES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            valid_cnt_reg <= valid_cnt_next;
            free_cnt_reg  <= free_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        rem_reg    <= rem_next;
        widx_reg   <= widx_next;
        word_reg   <= word_next;
        frame_reg  <= frame_next;
        out_reg    <= out_next;
    end

endmodule

[src/page_table_frame_allocator_top.sv]
// ----------------------------------------------------------------------------
// page_table_frame_allocator_top
// Bitmap frame allocator with a page table, stream request and result ports.
// ----------------------------------------------------------------------------
// A grow request assigns the lowest free frames to pages from the current
// count up to the target, one result per page; a shrink request releases
// pages from the top and frees their frames, one result per page. Rejected
// or empty requests give one status-only result. One request is worked on
// at a time. A grow loads each bitmap row of 32 frames it visits and steps
// over each full row, since the free frame search reads the bitmap RAM row by
// row from frame 0, and assigns one frame per page. A shrink takes each page
// through page table read, bitmap row read and row write back. A result
// stalled on the result port holds the sequencer. The bitmap is empty right
// after reset with no clearing pass. A new request is taken only while the
// output register is empty or its result transfers in the same cycle.
// ----------------------------------------------------------------------------
module page_table_frame_allocator_top
    import ptfa_pkg::*;
#(
    parameter int PAGES  = PTFA_PAGES,
    parameter int FRAMES = PTFA_FRAMES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] page_count, [7] zero
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [1:0] status, [7:2] page_index,
                                        // [15:8] frame_number,
                                        // [22:16] valid_pages, [23] zero
    output logic        m_axis_tuser,   // [0] changed
    output logic        m_axis_tlast    // last result of the request
);

    localparam int MAP_WORDS = (FRAMES + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int WIW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PIW       = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int FW        = $clog2(FRAMES);

    rsp_t                  rsp;
    logic                  map_rd_en;
    logic [WIW-1:0]        map_rd_addr;
    logic [MAP_WORD_W-1:0] map_rd_data;
    logic                  map_wr_en;
    logic [WIW-1:0]        map_wr_addr;
    logic [MAP_WORD_W-1:0] map_wr_data;
    logic                  tbl_rd_en;
    logic [PIW-1:0]        tbl_rd_addr;
    logic [FW-1:0]         tbl_rd_data;
    logic                  tbl_wr_en;
    logic [PIW-1:0]        tbl_wr_addr;
    logic [FW-1:0]         tbl_wr_data;

    ptfa_ctrl #(
        .PAGES  (PAGES),
        .FRAMES (FRAMES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req_kind    (s_axis_tuser),
        .req_count   (s_axis_tdata[6:0]),
        .rsp_valid   (m_axis_tvalid),
        .rsp_ready   (m_axis_tready),
        .rsp         (rsp),
        .map_rd_en   (map_rd_en),
        .map_rd_addr (map_rd_addr),
        .map_rd_data (map_rd_data),
        .map_wr_en   (map_wr_en),
        .map_wr_addr (map_wr_addr),
        .map_wr_data (map_wr_data),
        .tbl_rd_en   (tbl_rd_en),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data)
    );

    ptfa_bitmap #(
        .FRAMES (FRAMES)
    ) u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data)
    );

    ptfa_table #(
        .PAGES  (PAGES),
        .FRAMES (FRAMES)
    ) u_table (
        .clk     (clk),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    assign m_axis_tdata = {1'b0, rsp.valid_pages, rsp.frame_number,
                           rsp.page_index, rsp.status};
    assign m_axis_tuser = rsp.changed;
    assign m_axis_tlast = rsp.last;

endmodule

[src/ptfa_checker.sv]
// ----------------------------------------------------------------------------
// ptfa_checker
// Port-level checks of the allocator's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ptfa_checker
    import ptfa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Status-only transfer ends its request and carries no page or frame
    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tlast && (m_axis_tdata[15:2] == 14'd0))
        else $error("malformed status-only result");

    // Page changes are only reported with an ok status
    a_change_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == STATUS_OK)
        else $error("page change with error status");

    // No request is taken while a non-final result of the previous one waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("request taken during a multi-result request");

endmodule

bind page_table_frame_allocator_top ptfa_checker u_checker (.*);

[dv/tb_page_table_frame_allocator_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_table_frame_allocator_top
// Self-checking bench for the page table frame allocator.
// ----------------------------------------------------------------------------
// Grow and shrink requests go in on the request stream. A predictor keeps its
// own frame bitmap and page table and queues the result transfers that each
// accepted request should produce. A checker compares every result transfer,
// field by field, with the oldest queued one. Directed tests cover the empty
// table, the full table, oversize targets, clamped shrinks and frame reuse.
// A held-off result port fills the block, and random mixes run under
// several idle and stall patterns on both streams.
// ----------------------------------------------------------------------------
module tb_page_table_frame_allocator_top;
    import ptfa_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    // Quiet time after the last drain to catch any stray result
    localparam int TAIL_CYCLES = 500;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [6:0] page_count, [7] zero
    logic        s_axis_tuser;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;   // [1:0] status, [7:2] page_index,
                                 // [15:8] frame_number, [22:16] valid_pages
    logic        m_axis_tuser;   // [0] changed
    logic        m_axis_tlast;

    // Predictor state
    logic       frame_busy [PTFA_FRAMES];
    logic [7:0] page_frame_map [PTFA_PAGES];
    int         mapped_pages;
    int         free_frames;
    rsp_t       pending_results [$];

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_len;
    int hold_seq;
    int hold_seen = 0;
    int hold_left = 0;

    int cycle_count = 0;
    int error_count = 0;
    int grow_count = 0;
    int shrink_count = 0;
    int result_count = 0;
    int peak_pages = 0;
    int input_stall_cycles = 0;

    page_table_frame_allocator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (s_axis_tvalid && !s_axis_tready)
        begin
            input_stall_cycles++;
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_allocation_model();
        for (int f = 0; f < PTFA_FRAMES; f++)
        begin
            frame_busy[f] = 1'b0;
        end
        for (int p = 0; p < PTFA_PAGES; p++)
        begin
            page_frame_map[p] = '0;
        end
        mapped_pages = 0;
        free_frames  = PTFA_FRAMES;
    endfunction

    function automatic void queue_result(status_t st, int page, int frame,
                                         logic changed, logic last);
        rsp_t r;
        r.status       = st;
        r.page_index   = 6'(page);
        r.frame_number = 8'(frame);
        r.changed      = changed;
        r.valid_pages  = 7'(mapped_pages);
        r.last         = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_allocation(logic kind, logic [6:0] count);
        int target;
        int release_n;
        int frame;
        int page;
        target = count;
        if (kind == KIND_GROW)
        begin
            grow_count++;
            if (target > PTFA_PAGES)
            begin
                queue_result(STATUS_TOO_BIG, 0, 0, 1'b0, 1'b1);
            end
            else if (target <= mapped_pages)
            begin
                queue_result(STATUS_OK, 0, 0, 1'b0, 1'b1);
            end
            // Cannot fire with 64 pages over 256 frames
            else if (target - mapped_pages > free_frames)
            begin
                queue_result(STATUS_NO_FRAMES, 0, 0, 1'b0, 1'b1);
            end
            else
            begin
                while (mapped_pages < target)
                begin
                    frame = 0;
                    while (frame < PTFA_FRAMES - 1 && frame_busy[frame])
                    begin
                        frame++;
                    end
                    frame_busy[frame] = 1'b1;
                    free_frames--;
                    page = mapped_pages;
                    page_frame_map[page] = 8'(frame);
                    mapped_pages++;
                    queue_result(STATUS_OK, page, frame, 1'b1, mapped_pages == target);
                end
            end
        end
        else
        begin
            shrink_count++;
            release_n = (target > mapped_pages) ? mapped_pages : target;
            if (release_n == 0)
            begin
                queue_result(STATUS_OK, 0, 0, 1'b0, 1'b1);
            end
            for (int i = 0; i < release_n; i++)
            begin
                mapped_pages--;
                page  = mapped_pages;
                frame = page_frame_map[page];
                if (frame_busy[frame])
                begin
                    frame_busy[frame] = 1'b0;
                    free_frames++;
                end
                page_frame_map[page] = '0;
                queue_result(STATUS_OK, page, frame, 1'b1, i == release_n - 1);
            end
        end
        if (mapped_pages > peak_pages)
        begin
            peak_pages = mapped_pages;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_request(input logic kind, input logic [6:0] count);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, count};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predict_allocation(kind, count);
    endtask

    // Stop offering and wait for every queued result
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic report_mismatch(input string field, input int want, input int got);
        error_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        rsp_t got;
        rsp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count++;
            got.status       = status_t'(m_axis_tdata[1:0]);
            got.page_index   = m_axis_tdata[7:2];
            got.frame_number = m_axis_tdata[15:8];
            got.valid_pages  = m_axis_tdata[22:16];
            got.changed      = m_axis_tuser;
            got.last         = m_axis_tlast;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h %b %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", want.status, got.status);
                if (got.page_index !== want.page_index)
                    report_mismatch("page_index", want.page_index, got.page_index);
                if (got.frame_number !== want.frame_number)
                    report_mismatch("frame_number", want.frame_number, got.frame_number);
                if (got.changed !== want.changed)
                    report_mismatch("changed", want.changed, got.changed);
                if (got.valid_pages !== want.valid_pages)
                    report_mismatch("valid_pages", want.valid_pages, got.valid_pages);
                if (got.last !== want.last)
                    report_mismatch("last", want.last, got.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_table();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_request(KIND_SHRINK, 7'd5);
        send_request(KIND_SHRINK, 7'd0);
        send_request(KIND_GROW, 7'd0);
        send_request(KIND_GROW, 7'd1);
        send_request(KIND_SHRINK, 7'd1);
        drain_results();
    endtask

    task automatic test_grow_to_limit();
        send_request(KIND_GROW, 7'(PTFA_PAGES));
        send_request(KIND_GROW, 7'(PTFA_PAGES));
        send_request(KIND_GROW, 7'd40);
        send_request(KIND_GROW, 7'(PTFA_PAGES + 1));
        send_request(KIND_GROW, 7'd127);
        send_request(KIND_SHRINK, 7'd0);
        drain_results();
    endtask

    task automatic test_shrink_and_clamp();
        send_request(KIND_SHRINK, 7'd1);
        send_request(KIND_SHRINK, 7'd10);
        send_request(KIND_GROW, 7'(PTFA_PAGES));
        send_request(KIND_SHRINK, 7'd127);
        send_request(KIND_GROW, 7'd2);
        send_request(KIND_SHRINK, 7'd3);
        send_request(KIND_GROW, 7'd5);
        send_request(KIND_SHRINK, 7'd2);
        send_request(KIND_GROW, 7'd6);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        // Hold the result port long enough for the request port to back up
        hold_len = 400;
        hold_seq++;
        repeat (6)
        begin
            send_request(KIND_GROW, 7'(mapped_pages + 3));
        end
        drain_results();
    endtask

    task automatic test_random_mix(input int tx_pct, input int rx_pct, input int n);
        int pick;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_request(KIND_GROW, 7'(mapped_pages + $urandom_range(1, 6)));
            else if (pick < 74)
                send_request(KIND_SHRINK, 7'($urandom_range(1, 6)));
            else if (pick < 78)
                send_request(KIND_GROW, 7'(PTFA_PAGES));
            else if (pick < 82)
                send_request(KIND_SHRINK, 7'(PTFA_PAGES));
            else if (pick < 88)
                send_request(KIND_GROW, 7'($urandom_range(PTFA_PAGES + 1, 127)));
            else if (pick < 94)
                send_request(KIND_SHRINK, 7'($urandom_range(0, 127)));
            else
                send_request(KIND_GROW, 7'($urandom_range(0, mapped_pages)));
        end
        drain_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_GROW;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_len      = 0;
        hold_seq      = 0;
        clear_allocation_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_grow_to_limit();
        test_shrink_and_clamp();
        test_output_backpressure();
        test_random_mix(0, 0, 72);
        test_random_mix(87, 0, 72);
        test_random_mix(0, 87, 72);
        test_random_mix(15, 15, 72);

        rx_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d grow and %0d shrink requests, %0d results, peak %0d pages.",
                 grow_count, shrink_count, result_count, peak_pages);
        $display("Request port stalled %0d cycles; idle mixes: none, sender, receiver, both.",
                 input_stall_cycles);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
